>>> design/fdtdpu_pkg.sv
package fdtdpu_pkg;

    // Gains are Q1.30, air center Q2.30; gain products carry 30 extra fraction bits
    localparam int GAIN_BITS = 30;

    // Quotient bits produced by the absorbing-loss divider, one per stage
    localparam int DIV_STEPS = 34;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // 2.0 in Q5.30 signed
    localparam logic signed [34:0] CENTER_TWO = 35'sd2147483648;

    // Half an output LSB in the Q.30 product domain
    localparam logic signed [68:0] HALF_LSB = 69'sd536870912;

    // Configuration register indexes
    typedef enum logic [7:0] {
        REG_AIR_CENTER_GAIN = 8'd0,
        REG_NEIGHBOR_GAIN   = 8'd1,
        REG_COURANT_SQ      = 8'd2,
        REG_ABC_GAIN        = 8'd3
    } reg_index_t;

    // Point kinds
    typedef enum logic {
        MODE_AIR   = 1'b0,
        MODE_RIGID = 1'b1
    } point_mode_t;

    // Configuration register bank
    typedef struct packed {
        logic [31:0] air_center_gain;
        logic [30:0] neighbor_gain;
        logic [30:0] courant_sq;
        logic [30:0] abc_gain;
    } cfg_t;

    // One classified point, as it waits in the queue
    typedef struct packed {
        point_mode_t        mode;
        logic signed [34:0] center_weight;
        logic signed [31:0] center;
        logic signed [34:0] neighbor_sum;
        logic signed [31:0] previous;
        logic signed [31:0] source;
        logic [1:0]         abc_faces;
    } point_entry_t;

    // Saturate to the signed 32-bit range; bit 32 of the result is the clip flag
    function automatic logic [32:0] sat32(input logic signed [38:0] x);
        logic [32:0] res;
        if (x > 39'sd2147483647)
            res = {1'b1, 32'h7FFF_FFFF};
        else if (x < -39'sd2147483648)
            res = {1'b1, 32'h8000_0000};
        else
            res = {1'b0, x[31:0]};
        return res;
    endfunction

endpackage

>>> design/fdtdpu_front.sv
module fdtdpu_front (
    input  fdtdpu_pkg::cfg_t         cfg,
    input  logic                     s_tvalid,
    input  logic                     queue_full,
    output logic                     s_tready,
    input  logic [295:0]             s_tdata,
    input  logic                     s_tuser,
    output logic                     push,
    output fdtdpu_pkg::point_entry_t entry
);

    logic signed [31:0] nb [6];
    logic [5:0]         open_faces;
    logic [5:0]         mask;
    logic [2:0]         k;
    logic [33:0]        k_sl2;
    logic signed [34:0] nsum;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    // Unpack the neighbor samples
    assign nb[0]      = s_tdata[95:64];
    assign nb[1]      = s_tdata[127:96];
    assign nb[2]      = s_tdata[159:128];
    assign nb[3]      = s_tdata[191:160];
    assign nb[4]      = s_tdata[223:192];
    assign nb[5]      = s_tdata[255:224];
    assign open_faces = s_tdata[261:256];

    // Air points use all six neighbors, rigid points only the open faces
    assign mask  = (s_tuser == fdtdpu_pkg::MODE_RIGID) ? open_faces : 6'h3F;
    assign k     = 3'($countones(open_faces));
    assign k_sl2 = 34'(k) * 34'(cfg.courant_sq);

    always_comb
    begin
        nsum = '0;
        for (int i = 0; i < 6; i++)
        begin
            if (mask[i])
                nsum = nsum + 35'(nb[i]);
        end
    end

    // Classify and build the queue entry
    always_comb
    begin
        entry.mode         = fdtdpu_pkg::point_mode_t'(s_tuser);
        entry.center       = s_tdata[31:0];
        entry.previous     = s_tdata[63:32];
        entry.source       = s_tdata[293:262];
        entry.abc_faces    = s_tdata[295:294];
        entry.neighbor_sum = nsum;
        if (s_tuser == fdtdpu_pkg::MODE_RIGID)
            entry.center_weight = fdtdpu_pkg::CENTER_TWO - $signed({1'b0, k_sl2});
        else
            entry.center_weight = $signed({3'b000, cfg.air_center_gain});
    end

endmodule

>>> design/fdtdpu_queue.sv
module fdtdpu_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  fdtdpu_pkg::point_entry_t push_entry,
    input  logic                     pop,
    output fdtdpu_pkg::point_entry_t head,
    output logic                     full,
    output logic                     empty
);

    localparam int PW = $clog2(fdtdpu_pkg::QUEUE_DEPTH);

    fdtdpu_pkg::point_entry_t mem_reg [fdtdpu_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;

    assign full  = (count_reg == (PW+1)'(fdtdpu_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(fdtdpu_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(fdtdpu_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

>>> design/fdtdpu_back.sv
module fdtdpu_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  fdtdpu_pkg::cfg_t         cfg,
    input  fdtdpu_pkg::point_entry_t head,
    input  logic                     empty,
    output logic                     pop,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [31:0]              m_tdata,
    output logic                     m_tuser
);

    typedef struct packed {
        fdtdpu_pkg::point_mode_t mode;
        logic signed [66:0]      prod_c;
        logic signed [66:0]      prod_n;
        logic signed [31:0]      previous;
        logic signed [31:0]      source;
        logic [1:0]              abc_faces;
    } mul_stage_t;

    typedef struct packed {
        fdtdpu_pkg::point_mode_t mode;
        logic signed [31:0]      r;
        logic                    flag;
        logic signed [31:0]      previous;
        logic signed [31:0]      source;
        logic [1:0]              abc_faces;
    } rnd_stage_t;

    typedef struct packed {
        logic [33:0]        rem;
        logic [33:0]        low;
        logic [33:0]        quo;
        logic [32:0]        d;
        logic               neg;
        logic signed [31:0] u2;
        logic               flag;
    } div_stage_t;

    logic       en;
    mul_stage_t mul_reg;
    logic       mul_vld_reg;
    rnd_stage_t rnd_reg;
    logic       rnd_vld_reg;
    div_stage_t div_reg [fdtdpu_pkg::DIV_STEPS + 1];
    logic [fdtdpu_pkg::DIV_STEPS:0] div_vld_reg;
    logic [31:0] out_data_reg;
    logic        out_flag_reg;
    logic        out_vld_reg;

    // Whole back pipeline moves unless the output is held
    assign en       = !out_vld_reg || m_tready;
    assign pop      = en && !empty;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_flag_reg;

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            rnd_vld_reg <= 1'b0;
            div_vld_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            mul_vld_reg <= !empty;
            rnd_vld_reg <= mul_vld_reg;
            div_vld_reg <= {div_vld_reg[fdtdpu_pkg::DIV_STEPS-1:0], rnd_vld_reg};
            out_vld_reg <= div_vld_reg[fdtdpu_pkg::DIV_STEPS];
        end
    end

    // Multiply: center term and neighbor term
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mul_reg.mode      <= head.mode;
            mul_reg.prod_c    <= 67'(head.center_weight) * 67'(head.center);
            mul_reg.prod_n    <= 67'($signed({1'b0, cfg.neighbor_gain})) * 67'(head.neighbor_sum);
            mul_reg.previous  <= head.previous;
            mul_reg.source    <= head.source;
            mul_reg.abc_faces <= head.abc_faces;
        end
    end

    // Sum, round half up and saturate
    logic signed [32:0] lin;
    logic signed [68:0] acc;
    logic [32:0]        rsat;

    always_comb
    begin
        if (mul_reg.mode == fdtdpu_pkg::MODE_AIR)
            lin = 33'(mul_reg.previous) + 33'(mul_reg.source);
        else
            lin = 33'(mul_reg.previous);
        acc  = 69'(mul_reg.prod_c) + 69'(mul_reg.prod_n)
             - (69'(lin) <<< fdtdpu_pkg::GAIN_BITS) + fdtdpu_pkg::HALF_LSB;
        rsat = fdtdpu_pkg::sat32($signed(acc[68:fdtdpu_pkg::GAIN_BITS]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rnd_reg.mode      <= mul_reg.mode;
            rnd_reg.r         <= rsat[31:0];
            rnd_reg.flag      <= rsat[32];
            rnd_reg.previous  <= mul_reg.previous;
            rnd_reg.source    <= mul_reg.source;
            rnd_reg.abc_faces <= mul_reg.abc_faces;
        end
    end

    // Rigid source, absorbing divisor and rounded dividend
    logic [32:0]        vsat;
    logic signed [31:0] v;
    logic signed [31:0] u2;
    logic               flag;
    logic [32:0]        d;
    logic signed [64:0] np;
    logic               neg;
    logic [63:0]        mag;

    always_comb
    begin
        vsat = fdtdpu_pkg::sat32(39'(rnd_reg.r) + 39'(rnd_reg.source));
        if (rnd_reg.mode == fdtdpu_pkg::MODE_RIGID)
        begin
            v    = vsat[31:0];
            u2   = rnd_reg.r;
            flag = rnd_reg.flag | vsat[32];
        end
        else
        begin
            v    = rnd_reg.r;
            u2   = rnd_reg.previous;
            flag = rnd_reg.flag;
        end
        d   = (33'd1 << fdtdpu_pkg::GAIN_BITS) + 33'(cfg.abc_gain) * 33'(rnd_reg.abc_faces);
        np  = ((65'(v) - 65'(u2)) <<< fdtdpu_pkg::GAIN_BITS) + $signed({33'b0, d[32:1]});
        neg = np[64];
        // floor of a negative quotient: negate the ceiling of the magnitude
        if (neg)
            mag = 64'(-np + $signed({32'b0, d}) - 65'sd1);
        else
            mag = np[63:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg[0].rem  <= {4'b0000, mag[63:34]};
            div_reg[0].low  <= mag[33:0];
            div_reg[0].quo  <= '0;
            div_reg[0].d    <= d;
            div_reg[0].neg  <= neg;
            div_reg[0].u2   <= u2;
            div_reg[0].flag <= flag;
        end
    end

    // Restoring divider, one quotient bit per stage
    for (genvar i = 0; i < fdtdpu_pkg::DIV_STEPS; i++)
    begin : g_div
        logic [33:0] trial;
        logic        ge;

        assign trial = {div_reg[i].rem[32:0], div_reg[i].low[33]};
        assign ge    = (trial >= {1'b0, div_reg[i].d});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[i+1].rem  <= ge ? trial - {1'b0, div_reg[i].d} : trial;
                div_reg[i+1].low  <= {div_reg[i].low[32:0], 1'b0};
                div_reg[i+1].quo  <= {div_reg[i].quo[32:0], ge};
                div_reg[i+1].d    <= div_reg[i].d;
                div_reg[i+1].neg  <= div_reg[i].neg;
                div_reg[i+1].u2   <= div_reg[i].u2;
                div_reg[i+1].flag <= div_reg[i].flag;
            end
        end
    end

    // Apply sign and add back to u2
    logic signed [35:0] qs;
    logic signed [35:0] res;

    always_comb
    begin
        if (div_reg[fdtdpu_pkg::DIV_STEPS].neg)
            qs = -$signed({2'b00, div_reg[fdtdpu_pkg::DIV_STEPS].quo});
        else
            qs = $signed({2'b00, div_reg[fdtdpu_pkg::DIV_STEPS].quo});
        res = 36'(div_reg[fdtdpu_pkg::DIV_STEPS].u2) + qs;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= res[31:0];
            out_flag_reg <= div_reg[fdtdpu_pkg::DIV_STEPS].flag;
        end
    end

endmodule

>>> design/fdtd_point_update_unit.sv
// FDTD 7-point grid update. Takes one grid point per clock on the s_ side
// while s_tready is high and returns its next-step value on the m_ side in
// the same order. A point passes the 4-entry queue between the classifying
// front and the back pipeline, then the multiply, round and absorbing-loss
// setup registers, a 34-stage pipelined divider and the output register;
// the divider is what sets the depth. Throughput is one point per cycle
// while m_tready stays high. A held result freezes the whole back pipeline,
// and the queue then takes up to four more points before s_tready drops.
// Samples are Q8.24 signed (the fraction width only scales interpretation),
// gains are Q1.30 unsigned, the air center gain Q2.30 unsigned.
// Write gains only while no points are in flight.
module fdtd_point_update_unit (
    input  logic         clk,
    input  logic         rst_n,
    // Configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    // Input points
    input  logic         s_tvalid,
    output logic         s_tready,
    // center, previous, x_plus, x_minus, y_plus, y_minus, z_plus, z_minus,
    // open_faces, source, abc_faces
    input  logic [295:0] s_tdata,
    // mode
    input  logic         s_tuser,
    // Results
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_value
    output logic [31:0]  m_tdata,
    // saturated
    output logic         m_tuser
);

    fdtdpu_pkg::cfg_t         cfg_reg;
    fdtdpu_pkg::point_entry_t push_entry;
    fdtdpu_pkg::point_entry_t head;
    logic                     push;
    logic                     pop;
    logic                     full;
    logic                     empty;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.air_center_gain <= 32'd0;
            cfg_reg.neighbor_gain   <= 31'd357913941;
            cfg_reg.courant_sq      <= 31'd357913941;
            cfg_reg.abc_gain        <= 31'd619925131;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                fdtdpu_pkg::REG_AIR_CENTER_GAIN: cfg_reg.air_center_gain <= cfg_data;
                fdtdpu_pkg::REG_NEIGHBOR_GAIN:   cfg_reg.neighbor_gain   <= cfg_data[30:0];
                fdtdpu_pkg::REG_COURANT_SQ:      cfg_reg.courant_sq      <= cfg_data[30:0];
                fdtdpu_pkg::REG_ABC_GAIN:        cfg_reg.abc_gain        <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    fdtdpu_front u_front (
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .queue_full (full),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push       (push),
        .entry      (push_entry)
    );

    fdtdpu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .empty      (empty)
    );

    fdtdpu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> verif/fdtd_point_update_checker.sv
`timescale 1ns / 100ps

// Watches the config, point and result channels of the FDTD update unit,
// predicts each result and compares it with what comes out.
module fdtd_point_update_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [295:0] s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [31:0]  m_tdata,
    input  logic         m_tuser,
    output int           fail_count,
    output int           pending
);

    // Shadow gain registers
    logic [31:0] air_gain;
    logic [30:0] nb_gain;
    logic [30:0] csq_gain;
    logic [30:0] loss_gain;

    // Expected {saturated, new_value}, oldest first
    logic [32:0] update_q[$];

    function automatic logic signed [95:0] clip32(input logic signed [95:0] x,
                                                  inout logic flag);
        if (x > 96'sd2147483647)
        begin
            flag = 1'b1;
            return 96'sd2147483647;
        end
        if (x < -96'sd2147483648)
        begin
            flag = 1'b1;
            return -96'sd2147483648;
        end
        return x;
    endfunction

    // Next-step value of one grid point
    function automatic logic [32:0] point_update(input logic mode,
                                                 input logic [295:0] d);
        logic signed [95:0] acc, t, v, u2, n, den, num, quo;
        longint c, p, src, nb, a2;
        logic [5:0] faces;
        logic [1:0] q;
        logic flag;
        int k;
        c     = longint'($signed(d[31:0]));
        p     = longint'($signed(d[63:32]));
        faces = d[261:256];
        src   = longint'($signed(d[293:262]));
        q     = d[295:294];
        a2    = longint'(nb_gain);
        flag  = 1'b0;
        acc   = '0;
        k     = 0;
        if (mode == fdtdpu_pkg::MODE_AIR)
        begin
            t = longint'(air_gain) * c;
            acc = t;
            for (int i = 0; i < 6; i++)
            begin
                nb = longint'($signed(d[64 + 32*i +: 32]));
                t = a2 * nb;
                acc = acc + t;
            end
            t = p + src;
            acc = acc - (t <<< 30);
            v = clip32((acc + 96'sd536870912) >>> 30, flag);
            u2 = p;
        end
        else
        begin
            for (int i = 0; i < 6; i++)
            begin
                if (faces[i])
                begin
                    k++;
                    nb = longint'($signed(d[64 + 32*i +: 32]));
                    t = a2 * nb;
                    acc = acc + t;
                end
            end
            t = 2 * c - p;
            acc = acc + (t <<< 30);
            t = longint'(csq_gain) * c;
            acc = acc - 96'(k) * t;
            u2 = clip32((acc + 96'sd536870912) >>> 30, flag);
            v = clip32(u2 + src, flag);
        end
        // Absorbing edge loss
        if (q != 2'd0)
        begin
            den = 96'sd1073741824 + longint'(loss_gain) * longint'(q);
            n   = (v - u2) <<< 30;
            num = n + (den >>> 1);
            quo = num / den;
            if ((num % den) != 0 && num < 0)
                quo = quo - 1;
            v = u2 + quo;
        end
        return {flag, v[31:0]};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        logic [32:0] exp_r;
        if (!rst_n)
        begin
            air_gain   <= 32'd0;
            nb_gain    <= 31'd357913941;
            csq_gain   <= 31'd357913941;
            loss_gain  <= 31'd619925131;
            fail_count <= 0;
            pending    <= 0;
            update_q.delete();
        end
        else
        begin
            // Config transaction
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    fdtdpu_pkg::REG_AIR_CENTER_GAIN: air_gain  <= cfg_data;
                    fdtdpu_pkg::REG_NEIGHBOR_GAIN:   nb_gain   <= cfg_data[30:0];
                    fdtdpu_pkg::REG_COURANT_SQ:      csq_gain  <= cfg_data[30:0];
                    fdtdpu_pkg::REG_ABC_GAIN:        loss_gain <= cfg_data[30:0];
                    default: ;
                endcase
            end
            // Point transaction
            if (s_tvalid && s_tready)
                update_q.push_back(point_update(s_tuser, s_tdata));
            // Result transaction
            if (m_tvalid && m_tready)
            begin
                if (update_q.size() == 0)
                begin
                    $display("%0t: unexpected result value=%h sat=%b",
                             $time, m_tdata, m_tuser);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = update_q.pop_front();
                    if (exp_r[31:0] !== m_tdata || exp_r[32] !== m_tuser)
                    begin
                        $display("%0t: mismatch expected value=%h sat=%b %s=%h sat=%b",
                                 $time, exp_r[31:0], exp_r[32], "actual value",
                                 m_tdata, m_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= update_q.size();
        end
    end

endmodule

>>> verif/fdtd_point_update_unit_tb.sv
`timescale 1ns / 100ps

module fdtd_point_update_unit_tb;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [295:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic         m_tuser;
    int           fail_count;
    int           pending;
    int           burst_left;

    fdtd_point_update_unit dut (.*);

    fdtd_point_update_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #4ms;
        $display("FAILURE");
        $finish;
    end

    // Result side stalls: random stretches, each open, mostly ready or mostly held
    initial
    begin
        int mode_len;
        int choppy;
        m_tready = 1'b0;
        forever
        begin
            mode_len = $urandom_range(200, 10);
            choppy = $urandom_range(2, 0);
            repeat (mode_len)
            begin
                @(negedge clk);
                if (choppy == 0)
                    m_tready <= 1'b1;
                else if (choppy == 1)
                    m_tready <= ($urandom_range(3, 0) != 0);
                else
                    m_tready <= ($urandom_range(3, 0) == 0);
            end
        end
    end

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(5, 0))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom();
            default: return 32'($signed($urandom_range(32'h0800_0000, 0)) - 32'sh0400_0000);
        endcase
    endfunction

    task automatic cfg_write(input fdtdpu_pkg::reg_index_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // One point transaction; valid stays high across a burst
    task automatic send_point(input logic mode, input logic [31:0] c,
                              input logic [31:0] p, input logic [31:0] nb[6],
                              input logic [5:0] faces, input logic [31:0] src,
                              input logic [1:0] q);
        @(negedge clk);
        if (burst_left == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge clk);
            burst_left = $urandom_range(30, 1);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = {q, src, faces, nb[5], nb[4], nb[3], nb[2], nb[1], nb[0], p, c};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_random();
        logic [31:0] nb[6];
        for (int i = 0; i < 6; i++)
            nb[i] = rand_sample();
        send_point(1'($urandom_range(1, 0)), rand_sample(), rand_sample(), nb,
                   6'($urandom_range(63, 0)),
                   ($urandom_range(3, 0) == 0) ? 32'd0 : rand_sample(),
                   2'($urandom_range(3, 0)));
    endtask

    // Drain all results, then let the pipeline empty
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic directed();
        logic [31:0] nb[6];
        logic [31:0] lim[4];
        lim = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF};
        for (int j = 0; j < 4; j++)
        begin
            for (int i = 0; i < 6; i++)
                nb[i] = lim[j];
            send_point(fdtdpu_pkg::MODE_AIR, lim[j], lim[3 - j], nb, 6'h3F, lim[j], 2'd0);
            send_point(fdtdpu_pkg::MODE_RIGID, lim[j], lim[3 - j], nb, 6'h3F, lim[j], 2'd3);
        end
        for (int i = 0; i < 6; i++)
            nb[i] = 32'h0100_0000;
        // every absorbing face count, each point kind
        for (int q = 0; q < 4; q++)
        begin
            send_point(fdtdpu_pkg::MODE_AIR, 32'h0200_0000, 32'hFF00_0000, nb, 6'h00,
                       32'h0000_8000, 2'(q));
            send_point(fdtdpu_pkg::MODE_RIGID, 32'h0200_0000, 32'hFF00_0000, nb, 6'h15,
                       32'h0000_8000, 2'(q));
        end
        // rigid with no open faces, and one face at a time
        send_point(fdtdpu_pkg::MODE_RIGID, 32'h0123_4567, 32'h0000_0001, nb, 6'h00,
                   32'd0, 2'd0);
        for (int i = 0; i < 6; i++)
            send_point(fdtdpu_pkg::MODE_RIGID, 32'hF000_0001, 32'd3, nb, 6'(1 << i),
                       32'd0, 2'd1);
        // rigid result clips before the source pulls it back
        send_point(fdtdpu_pkg::MODE_RIGID, 32'h7FFF_FFFF, 32'h8000_0000, nb, 6'h00,
                   32'h8000_0000, 2'd0);
    endtask

    initial
    begin
        logic [31:0] gains[6][4];
        gains = '{
            '{32'd0, 32'd357913941, 32'd357913941, 32'd619925131},
            '{32'h8000_0000, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000},
            '{32'd0, 32'd0, 32'd0, 32'd0},
            '{32'h7FFF_FFFF, 32'h4000_0000, 32'd0, 32'd1},
            '{32'h5555_5555, 32'd178956970, 32'd178956970, 32'd310000000},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}
        };
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = 8'd0;
        cfg_data   = 32'd0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        burst_left = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < 6; ph++)
        begin
            cfg_write(fdtdpu_pkg::REG_AIR_CENTER_GAIN, gains[ph][0]);
            cfg_write(fdtdpu_pkg::REG_NEIGHBOR_GAIN, gains[ph][1]);
            cfg_write(fdtdpu_pkg::REG_COURANT_SQ, gains[ph][2]);
            cfg_write(fdtdpu_pkg::REG_ABC_GAIN, gains[ph][3]);
            if (ph == 0 || ph == 1)
                directed();
            repeat (340) send_random();
            drain();
        end

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
